/* sv/vca_pkg.sv */
// Shared types and codes for the voice channel allocator.
package vca_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int CHAN_W   = 4;
   localparam int CFG_W    = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd8;

   localparam logic [ACTION_W-1:0] ACT_START        = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_STOP_EMITTER = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP_INDEX   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_STOP_ALL     = 2'd3;

   localparam logic [STATUS_W-1:0] STS_GRANTED  = 2'd0;
   localparam logic [STATUS_W-1:0] STS_DROPPED  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_FREED    = 2'd2;
   localparam logic [STATUS_W-1:0] STS_NO_MATCH = 2'd3;

endpackage

/* sv/vca_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/voice_channel_allocator_core.sv */
// Voice channel allocator: top level with scan sequencer and channel table.
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready  tuser: action; tdata: emitter, pickup, volume, index
//  rsp_     out  rsp_tvalid/rsp_tready  tuser: status; tdata: chosen_channel, stole_busy
//  csr_     in   csr_valid/csr_ready    csr_data: channels_in_use
//
// Start and stop-by-emitter walk the n channels in use through the table RAM read port,
// one channel a cycle. Stop-by-index and stop-all skip the scan and go straight to finish.
// The output register holds a result until taken; the next request beat is accepted
// once that result is loaded. Reset is synchronous; it clears busy and written bits,
// so the table needs no clearing pass. csr_ready is always high.
module voice_channel_allocator_core #(
   parameter int MAX_CHANNELS = 16,
   parameter int EMITTER_BITS = 16,
   parameter int VOLUME_BITS  = 10,
   localparam int REQ_W = ((EMITTER_BITS + VOLUME_BITS + 5 + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // csr
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vca_pkg::CFG_W-1:0]     csr_data,
   // request
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_W-1:0]              req_tdata,  // emitter_id, pickup_class, sound_volume,
                                                     // channel_index, zero pad
   input  logic [vca_pkg::ACTION_W-1:0]  req_tuser,  // action
   // response
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // chosen_channel, stole_busy, zero pad
   output logic [vca_pkg::STATUS_W-1:0]  rsp_tuser   // status
);

   import vca_pkg::*;

   localparam int IW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CW    = $clog2(MAX_CHANNELS + 1);
   localparam int NW    = (CW > CFG_W) ? CW : CFG_W;
   localparam int XW    = (CW > CHAN_W) ? CW : CHAN_W;
   localparam int RAM_W = EMITTER_BITS + VOLUME_BITS + 1;

   // request fields
   logic [EMITTER_BITS-1:0] req_emitter;
   logic                    req_pickup;
   logic [VOLUME_BITS-1:0]  req_volume;
   logic [CHAN_W-1:0]       req_index;

   assign req_emitter = req_tdata[EMITTER_BITS-1:0];
   assign req_pickup  = req_tdata[EMITTER_BITS];
   assign req_volume  = req_tdata[EMITTER_BITS+VOLUME_BITS:EMITTER_BITS+1];
   assign req_index   = req_tdata[EMITTER_BITS+VOLUME_BITS+CHAN_W:EMITTER_BITS+VOLUME_BITS+1];

   state_type state_ff, state_in;

   logic [CFG_W-1:0]        cfg_ff, cfg_in;
   logic [ACTION_W-1:0]     act_ff, act_in;
   logic [EMITTER_BITS-1:0] emit_ff, emit_in;
   logic                    pcls_ff, pcls_in;
   logic [VOLUME_BITS-1:0]  vol_ff, vol_in;
   logic [CHAN_W-1:0]       idx_ff, idx_in;
   logic [CW-1:0]           ptr_ff, ptr_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [IW-1:0]           chk_idx_ff, chk_idx_in;
   logic                    m_hit_ff, m_hit_in;
   logic [IW-1:0]           m_idx_ff, m_idx_in;
   logic                    f_hit_ff, f_hit_in;
   logic [IW-1:0]           f_idx_ff, f_idx_in;
   logic                    l_hit_ff, l_hit_in;
   logic [IW-1:0]           l_idx_ff, l_idx_in;
   logic [VOLUME_BITS:0]    l_vol_ff, l_vol_in;
   logic [MAX_CHANNELS-1:0] busy_ff, busy_in;
   logic [MAX_CHANNELS-1:0] wrtn_ff, wrtn_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [STATUS_W-1:0]     rsp_sts_ff, rsp_sts_in;
   logic [CHAN_W-1:0]       rsp_chan_ff, rsp_chan_in;
   logic                    rsp_stole_ff, rsp_stole_in;

   // active channel count, saturated to the table size
   logic [NW-1:0] cfg_wide;
   logic [NW-1:0] n_wide;
   logic [CW-1:0] n;

   assign cfg_wide = NW'(cfg_ff);
   assign n_wide   = (cfg_wide > NW'(MAX_CHANNELS)) ? NW'(MAX_CHANNELS) : cfg_wide;
   assign n        = n_wide[CW-1:0];

   logic [MAX_CHANNELS-1:0] inuse_mask;
   logic                    idx_busy;

   always_comb begin
      idx_busy = 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         inuse_mask[i] = (CW'(i) < n);
         if (XW'(idx_ff) == XW'(i)) begin
            idx_busy = busy_ff[i];
         end
      end
   end

   // channel table: {pickup, volume, emitter}
   logic             ram_we;
   logic [IW-1:0]    ram_waddr;
   logic [RAM_W-1:0] ram_wdata;
   logic [IW-1:0]    ram_raddr;
   logic [RAM_W-1:0] ram_q;

   assign ram_raddr = (ptr_ff < n) ? ptr_ff[IW-1:0] : '0;

   vca_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_CHANNELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   // never-written entries read as zero
   logic [RAM_W-1:0]        ent;
   logic [EMITTER_BITS-1:0] ent_emit;
   logic [VOLUME_BITS-1:0]  ent_vol;
   logic                    ent_pcls;
   logic                    ent_busy;

   assign ent      = wrtn_ff[chk_idx_ff] ? ram_q : '0;
   assign ent_emit = ent[EMITTER_BITS-1:0];
   assign ent_vol  = ent[EMITTER_BITS+VOLUME_BITS-1:EMITTER_BITS];
   assign ent_pcls = ent[RAM_W-1];
   assign ent_busy = busy_ff[chk_idx_ff];

   // final decision, from the scan results
   logic                fin_grant;
   logic [IW-1:0]       fin_idx;
   logic [STATUS_W-1:0] fin_sts;
   logic [CHAN_W-1:0]   fin_chan;
   logic                fin_stole;
   logic [XW-1:0]       fin_idx_wide;

   assign fin_idx_wide = XW'(fin_idx);

   always_comb begin
      fin_grant = 1'b0;
      fin_idx   = '0;
      fin_sts   = STS_NO_MATCH;
      fin_chan  = '0;
      fin_stole = 1'b0;
      unique case (act_ff)
         ACT_START: begin
            priority if (m_hit_ff) begin
               fin_grant = 1'b1;
               fin_idx   = m_idx_ff;
            end else if (f_hit_ff) begin
               fin_grant = 1'b1;
               fin_idx   = f_idx_ff;
            end else if (l_hit_ff) begin
               fin_grant = 1'b1;
               fin_idx   = l_idx_ff;
            end else begin
               fin_grant = 1'b0;
            end
            if (fin_grant) begin
               fin_sts   = STS_GRANTED;
               fin_chan  = fin_idx_wide[CHAN_W-1:0];
               fin_stole = busy_ff[fin_idx];
            end else begin
               fin_sts = STS_DROPPED;
            end
         end
         ACT_STOP_EMITTER: begin
            fin_idx = m_idx_ff;
            if (m_hit_ff) begin
               fin_sts  = STS_FREED;
               fin_chan = fin_idx_wide[CHAN_W-1:0];
            end
         end
         ACT_STOP_INDEX: begin
            if ((XW'(idx_ff) < XW'(n)) && idx_busy) begin
               fin_sts  = STS_FREED;
               fin_chan = idx_ff;
            end
         end
         ACT_STOP_ALL: begin
            if (|(busy_ff & inuse_mask)) begin
               fin_sts = STS_FREED;
            end
         end
         default: begin
            fin_sts = STS_NO_MATCH;
         end
      endcase
   end

   logic load;

   assign load       = (state_ff == ST_FINISH) && (!rsp_vld_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in     = state_ff;
      cfg_in       = cfg_ff;
      act_in       = act_ff;
      emit_in      = emit_ff;
      pcls_in      = pcls_ff;
      vol_in       = vol_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      m_hit_in     = m_hit_ff;
      m_idx_in     = m_idx_ff;
      f_hit_in     = f_hit_ff;
      f_idx_in     = f_idx_ff;
      l_hit_in     = l_hit_ff;
      l_idx_in     = l_idx_ff;
      l_vol_in     = l_vol_ff;
      busy_in      = busy_ff;
      wrtn_in      = wrtn_ff;
      rsp_vld_in   = rsp_tready ? 1'b0 : rsp_vld_ff;
      rsp_sts_in   = rsp_sts_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_stole_in = rsp_stole_ff;
      ram_we       = 1'b0;
      ram_waddr    = fin_idx;
      ram_wdata    = {pcls_ff, vol_ff, emit_ff};

      if (csr_valid) begin
         cfg_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in   = req_tuser;
               emit_in  = req_emitter;
               pcls_in  = req_pickup;
               vol_in   = req_volume;
               idx_in   = req_index;
               ptr_in   = '0;
               m_hit_in = 1'b0;
               f_hit_in = 1'b0;
               l_hit_in = 1'b0;
               // steal threshold starts one above the request volume
               l_vol_in = {1'b0, req_volume} + 1'b1;
               if ((req_tuser == ACT_START || req_tuser == ACT_STOP_EMITTER) && (n != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (ptr_ff < n) begin
               chk_vld_in = 1'b1;
               chk_idx_in = ptr_ff[IW-1:0];
               ptr_in     = ptr_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               if (act_ff == ACT_START) begin
                  if (!m_hit_ff && ent_emit == emit_ff && ent_pcls == pcls_ff) begin
                     m_hit_in = 1'b1;
                     m_idx_in = chk_idx_ff;
                  end
                  if (!f_hit_ff && !ent_busy) begin
                     f_hit_in = 1'b1;
                     f_idx_in = chk_idx_ff;
                  end
                  // strict compare keeps the first channel of lowest volume
                  if ({1'b0, ent_vol} < l_vol_ff) begin
                     l_hit_in = 1'b1;
                     l_idx_in = chk_idx_ff;
                     l_vol_in = {1'b0, ent_vol};
                  end
               end else begin
                  if (!m_hit_ff && ent_busy && ent_emit == emit_ff) begin
                     m_hit_in = 1'b1;
                     m_idx_in = chk_idx_ff;
                  end
               end
               if (CW'(chk_idx_ff) + 1'b1 == n) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (load) begin
               state_in     = ST_IDLE;
               rsp_vld_in   = 1'b1;
               rsp_sts_in   = fin_sts;
               rsp_chan_in  = fin_chan;
               rsp_stole_in = fin_stole;
               unique case (act_ff)
                  ACT_START: begin
                     if (fin_grant) begin
                        ram_we           = 1'b1;
                        busy_in[fin_idx] = 1'b1;
                        wrtn_in[fin_idx] = 1'b1;
                     end
                  end
                  ACT_STOP_EMITTER: begin
                     if (m_hit_ff) begin
                        busy_in[fin_idx] = 1'b0;
                     end
                  end
                  ACT_STOP_INDEX: begin
                     for (int i = 0; i < MAX_CHANNELS; i++) begin
                        if (XW'(idx_ff) == XW'(i) && inuse_mask[i]) begin
                           busy_in[i] = 1'b0;
                        end
                     end
                  end
                  ACT_STOP_ALL: begin
                     busy_in = busy_ff & ~inuse_mask;
                  end
                  default: begin
                     busy_in = busy_ff;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= CFG_RESET;
         chk_vld_ff <= 1'b0;
         busy_ff    <= '0;
         wrtn_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         chk_vld_ff <= chk_vld_in;
         busy_ff    <= busy_in;
         wrtn_ff    <= wrtn_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      emit_ff      <= emit_in;
      pcls_ff      <= pcls_in;
      vol_ff       <= vol_in;
      idx_ff       <= idx_in;
      ptr_ff       <= ptr_in;
      chk_idx_ff   <= chk_idx_in;
      m_hit_ff     <= m_hit_in;
      m_idx_ff     <= m_idx_in;
      f_hit_ff     <= f_hit_in;
      f_idx_ff     <= f_idx_in;
      l_hit_ff     <= l_hit_in;
      l_idx_ff     <= l_idx_in;
      l_vol_ff     <= l_vol_in;
      rsp_sts_ff   <= rsp_sts_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_stole_ff <= rsp_stole_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_sts_ff;
   assign rsp_tdata  = {3'b000, rsp_stole_ff, rsp_chan_ff};

   // one request at a time: no beat is taken right after one was
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a request is in progress");

   // scan never looks past the channels in use
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (CW'(chk_idx_ff) < n))
      else $error("scan index beyond active channel count");

   // a granted channel is busy afterwards
   a_grant_busy: assert property (@(posedge clock) disable iff (reset)
      load && fin_grant |=> busy_ff[$past(fin_idx)])
      else $error("granted channel not marked busy");

   // stop all leaves no active channel busy
   a_stop_all_clears: assert property (@(posedge clock) disable iff (reset)
      load && act_ff == ACT_STOP_ALL |=> (busy_ff & inuse_mask) == '0)
      else $error("stop all left an active channel busy");

endmodule
